// File: hw/rtl/top_k_logit_selector_macros.svh
// ----------------------------------------------------------------------------
// top_k_logit_selector_macros
// Assertion macros for the top-K logit selector.
// ----------------------------------------------------------------------------
`ifndef TOP_K_LOGIT_SELECTOR_MACROS_SVH
`define TOP_K_LOGIT_SELECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define TKS_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define TKS_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`else
`define TKS_ASSERT(label, cond)
`define TKS_ASSERT_IMPL(label, pre, post)
`endif
`endif

// File: hw/rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared constants and the float ordering key for the top-K selector.
// ----------------------------------------------------------------------------
package tks_pkg;
    localparam int RankW  = 4;
    localparam int IndexW = 18;
    localparam int ValueW = 32;

    function automatic logic [31:0] order_key(input logic [31:0] bits);
        logic [31:0] key;
        if (bits[30:0] > 31'h7F800000)
        begin
            key = 32'h0;
        end
        else if (bits[30:0] == 31'h0)
        begin
            key = 32'h80000000;
        end
        else if (bits[31])
        begin
            key = ~bits;
        end
        else
        begin
            key = bits | 32'h80000000;
        end
        return key;
    endfunction
endpackage

// File: hw/rtl/top_k_logit_selector.sv
// ----------------------------------------------------------------------------
// top_k_logit_selector
// Streaming selection of the TOP_K largest single-precision logits.
// ----------------------------------------------------------------------------
// One logit item is accepted per cycle while ready is high. Each item is
// registered, then inserted into a TOP_K-entry sorted list by a parallel
// compare-and-shift. After the last item the sorted list is copied into a
// result buffer, which emits TOP_K result items, one per cycle while
// out_ready is high, as the next vector streams in. A last item that reaches
// the insertion stage while the buffer still holds results waits there, and
// input stalls, until the edge after the final rank of the earlier vector is
// taken. Rank 0 is offered once the last item is flushed to the buffer.
`include "top_k_logit_selector_macros.svh"
module top_k_logit_selector #(
    parameter int TOP_K     = 10,
    parameter int MAX_VOCAB = 262144
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tks_pkg::ValueW-1:0]  value_bits,
    input  logic                        last,
    input  logic                        valid,
    output logic                        ready,
    output logic [tks_pkg::RankW-1:0]   rank,
    output logic [tks_pkg::IndexW-1:0]  token_index,
    output logic [tks_pkg::ValueW-1:0]  top_value_bits,
    output logic                        valid_res,
    output logic                        nonfinite,
    output logic                        too_long,
    output logic                        last_result,
    output logic                        out_valid,
    input  logic                        out_ready
);
    import tks_pkg::*;

    localparam int CntW = $clog2(MAX_VOCAB + 1);
    localparam int KW   = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_VOCAB);
    localparam logic [CntW-1:0] MaxIdx  = CntW'(MAX_VOCAB - 1);
    localparam logic [KW-1:0]   LastK   = KW'(TOP_K - 1);

    logic                  in_vld_reg;
    logic [ValueW-1:0]     in_bits_reg;
    logic [CntW-1:0]       in_idx_reg;
    logic                  in_last_reg;
    logic [CntW-1:0]       count_reg;
    logic                  nf_reg;
    logic                  ovf_reg;

    logic [ValueW-1:0]     kv_reg [TOP_K];
    logic [CntW-1:0]       ki_reg [TOP_K];
    logic [TOP_K-1:0]      kval_reg;
    logic [ValueW-1:0]     kv_next [TOP_K];
    logic [CntW-1:0]       ki_next [TOP_K];
    logic [TOP_K-1:0]      kval_next;
    logic [TOP_K-1:0]      beats;

    logic [ValueW-1:0]     ov_reg [TOP_K];
    logic [CntW-1:0]       oi_reg [TOP_K];
    logic [TOP_K-1:0]      oval_reg;
    logic                  onf_reg;
    logic                  oovf_reg;
    logic                  obusy_reg;
    logic [KW-1:0]         optr_reg;

    logic accept;
    logic blocked;
    logic advance;
    logic flush;
    logic out_fire;
    logic out_done;
    logic [31:0] new_key;

    assign out_fire = obusy_reg && out_ready;
    assign out_done = out_fire && (optr_reg == LastK);
    // A pending flush needs the buffer free; stall input while it is blocked.
    assign blocked  = in_vld_reg && in_last_reg && obusy_reg;
    assign advance  = in_vld_reg && !blocked;
    assign flush    = advance && in_last_reg;
    assign ready    = !blocked;
    assign accept   = valid && ready;
    assign new_key  = order_key(in_bits_reg);

    always_comb
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            beats[i] = !kval_reg[i] || (order_key(kv_reg[i]) < new_key);
        end
        for (int i = 0; i < TOP_K; i++)
        begin
            kv_next[i]   = kv_reg[i];
            ki_next[i]   = ki_reg[i];
            kval_next[i] = kval_reg[i];
            if (beats[i])
            begin
                if (i == 0 || !beats[(i == 0) ? 0 : i - 1])
                begin
                    kv_next[i]   = in_bits_reg;
                    ki_next[i]   = in_idx_reg;
                    kval_next[i] = 1'b1;
                end
                else
                begin
                    kv_next[i]   = kv_reg[(i == 0) ? 0 : i - 1];
                    ki_next[i]   = ki_reg[(i == 0) ? 0 : i - 1];
                    kval_next[i] = kval_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            count_reg  <= '0;
            nf_reg     <= 1'b0;
            ovf_reg    <= 1'b0;
            kval_reg   <= '0;
            obusy_reg  <= 1'b0;
            optr_reg   <= '0;
            onf_reg    <= 1'b0;
            oovf_reg   <= 1'b0;
            oval_reg   <= '0;
        end
        else
        begin
            in_vld_reg <= accept || blocked;
            if (accept)
            begin
                if (last)
                begin
                    count_reg <= '0;
                end
                else if (count_reg != MaxCnt)
                begin
                    count_reg <= count_reg + CntW'(1);
                end
            end
            if (advance)
            begin
                if (in_last_reg)
                begin
                    kval_reg <= '0;
                    nf_reg   <= 1'b0;
                    ovf_reg  <= 1'b0;
                    oval_reg <= kval_next;
                    onf_reg  <= nf_reg || (in_bits_reg[30:23] == 8'hFF);
                    oovf_reg <= ovf_reg || (in_idx_reg == MaxCnt);
                end
                else
                begin
                    kval_reg <= kval_next;
                    nf_reg   <= nf_reg || (in_bits_reg[30:23] == 8'hFF);
                    ovf_reg  <= ovf_reg || (in_idx_reg == MaxCnt);
                end
            end
            if (flush)
            begin
                obusy_reg <= 1'b1;
                optr_reg  <= '0;
            end
            else if (out_done)
            begin
                obusy_reg <= 1'b0;
            end
            else if (out_fire)
            begin
                optr_reg <= optr_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_bits_reg <= value_bits;
            in_idx_reg  <= count_reg;
            in_last_reg <= last;
        end
        if (advance)
        begin
            kv_reg <= kv_next;
            ki_reg <= ki_next;
        end
        if (flush)
        begin
            ov_reg <= kv_next;
            oi_reg <= ki_next;
        end
    end

    logic [CntW-1:0] sel_idx;
    assign sel_idx        = (oi_reg[optr_reg] == MaxCnt) ? MaxIdx : oi_reg[optr_reg];
    assign out_valid      = obusy_reg;
    assign rank           = RankW'(optr_reg);
    assign valid_res      = oval_reg[optr_reg];
    assign token_index    = valid_res ? IndexW'(sel_idx) : '0;
    assign top_value_bits = valid_res ? ov_reg[optr_reg] : '0;
    assign nonfinite      = onf_reg;
    assign too_long       = oovf_reg;
    assign last_result    = (optr_reg == LastK);

    `TKS_ASSERT_IMPL(a_no_flush_busy, flush, !obusy_reg)
    `TKS_ASSERT_IMPL(a_rank0_first, $rose(obusy_reg), optr_reg == '0)
    `TKS_ASSERT_IMPL(a_ptr_range, obusy_reg, optr_reg <= LastK)
    `TKS_ASSERT_IMPL(a_valid_prefix, obusy_reg && valid_res && optr_reg != '0, oval_reg[optr_reg - KW'(1)])
endmodule

// File: tb/top_k_logit_selector_checker.sv
// ----------------------------------------------------------------------------
// top_k_logit_selector_checker
// Watches both channels of the top-K logit selector and checks every result.
// ----------------------------------------------------------------------------
// Each accepted logit item goes into a local sorted top-K list. A last item
// queues one expected result per rank and then clears the list. Each
// accepted result is compared field by field with the oldest expected one.
module top_k_logit_selector_checker #(
    parameter int TOP_K     = 10,
    parameter int MAX_VOCAB = 262144
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tks_pkg::ValueW-1:0]  value_bits,
    input  logic                        last,
    input  logic                        valid,
    input  logic                        ready,
    input  logic [tks_pkg::RankW-1:0]   rank,
    input  logic [tks_pkg::IndexW-1:0]  token_index,
    input  logic [tks_pkg::ValueW-1:0]  top_value_bits,
    input  logic                        valid_res,
    input  logic                        nonfinite,
    input  logic                        too_long,
    input  logic                        last_result,
    input  logic                        out_valid,
    input  logic                        out_ready,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [tks_pkg::RankW-1:0]  rank;
        logic [tks_pkg::IndexW-1:0] token_index;
        logic [tks_pkg::ValueW-1:0] value;
        logic                       valid_res;
        logic                       nonfinite;
        logic                       too_long;
        logic                       last_result;
    } ranked_logit_t;

    logic [31:0]                slot_value [TOP_K];
    logic [tks_pkg::IndexW-1:0] best_index [TOP_K];
    logic                       best_used  [TOP_K];
    int unsigned                logit_count;
    logic                       any_nonfinite;
    logic                       vector_overflow;
    ranked_logit_t              ranked_results_q[$];

    function automatic logic [31:0] float_sort_key(input logic [31:0] b);
        if (b[30:23] == 8'hFF && b[22:0] != 0)
            return 32'h0;
        if (b[30:0] == 0)
            return 32'h8000_0000;
        return b[31] ? ~b : {1'b1, b[30:0]};
    endfunction

    task automatic clear_top_list();
        for (int i = 0; i < TOP_K; i++)
        begin
            slot_value[i] = '0;
            best_index[i] = '0;
            best_used[i]  = 1'b0;
        end
        logit_count     = 0;
        any_nonfinite   = 0;
        vector_overflow = 0;
    endtask

    task automatic take_logit(input logic [31:0] b, input logic is_last);
        int unsigned   idx;
        int            pos;
        ranked_logit_t r;
        if (logit_count < MAX_VOCAB)
        begin
            idx = logit_count;
            logit_count++;
        end
        else
        begin
            idx = MAX_VOCAB - 1;
            vector_overflow = 1;
        end
        if (b[30:23] == 8'hFF)
            any_nonfinite = 1;
        pos = 0;
        while (pos < TOP_K && best_used[pos]
               && float_sort_key(slot_value[pos]) >= float_sort_key(b))
            pos++;
        if (pos < TOP_K)
        begin
            for (int i = TOP_K - 1; i > pos; i--)
            begin
                slot_value[i] = slot_value[i-1];
                best_index[i] = best_index[i-1];
                best_used[i]  = best_used[i-1];
            end
            slot_value[pos] = b;
            best_index[pos] = tks_pkg::IndexW'(idx);
            best_used[pos]  = 1'b1;
        end
        if (is_last)
        begin
            for (int k = 0; k < TOP_K; k++)
            begin
                r.rank        = tks_pkg::RankW'(k);
                r.token_index = best_used[k] ? best_index[k] : '0;
                r.value       = best_used[k] ? slot_value[k] : '0;
                r.valid_res   = best_used[k];
                r.nonfinite   = any_nonfinite;
                r.too_long    = vector_overflow;
                r.last_result = (k == TOP_K - 1);
                ranked_results_q.push_back(r);
            end
            clear_top_list();
        end
    endtask

    task automatic check_ranked_logit();
        ranked_logit_t e;
        ranked_logit_t a;
        a = '{rank, token_index, top_value_bits, valid_res, nonfinite, too_long,
              last_result};
        if (ranked_results_q.size() == 0)
        begin
            $display("%0t: unexpected result, actual %p", $time, a);
            fail_count++;
            return;
        end
        e = ranked_results_q.pop_front();
        if (e !== a)
        begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, a);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        clear_top_list();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_ranked_logit();
            if (valid && ready)
                take_logit(value_bits, last);
        end
        pending <= ranked_results_q.size();
    end
endmodule

// File: tb/top_k_logit_selector_tb.sv
// ----------------------------------------------------------------------------
// top_k_logit_selector_tb
// Stimulus and verdict for the top-K logit selector.
// ----------------------------------------------------------------------------
// Directed vectors cover short vectors, ties, signed zeros, infinities and
// NaNs, then random vectors, a long receiver stall and drain pauses. A
// separate checker predicts and compares every result.
module top_k_logit_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_K     = 10;
    localparam int MAX_VOCAB = 262144;
    localparam int IDLE_LIMIT = 4000;

    logic                        clk;
    logic                        rst_n;
    logic [tks_pkg::ValueW-1:0]  value_bits;
    logic                        last;
    logic                        valid;
    logic                        ready;
    logic [tks_pkg::RankW-1:0]   rank;
    logic [tks_pkg::IndexW-1:0]  token_index;
    logic [tks_pkg::ValueW-1:0]  top_value_bits;
    logic                        valid_res;
    logic                        nonfinite;
    logic                        too_long;
    logic                        last_result;
    logic                        out_valid;
    logic                        out_ready;
    int                          fail_count;
    int                          pending;
    logic                        no_gaps;
    logic                        stall_request;
    int                          quiet_cycles;

    top_k_logit_selector #(.TOP_K(TOP_K), .MAX_VOCAB(MAX_VOCAB)) u_top (.*);

    top_k_logit_selector_checker #(.TOP_K(TOP_K), .MAX_VOCAB(MAX_VOCAB)) u_checker (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((valid && ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("top_k_logit_selector regression: fail");
            $finish;
        end
    end

    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 0;
                out_ready <= 0;
                repeat (300) @(negedge clk);
            end
            out_ready <= no_gaps || ($urandom_range(99) >= 12);
        end
    end

    task automatic send_logit(input logic [31:0] b, input logic is_last);
        @(negedge clk);
        valid      <= 1;
        value_bits <= b;
        last       <= is_last;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        if (!no_gaps && $urandom_range(99) < 12)
        begin
            @(negedge clk);
            valid <= 0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] pick_logit();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(9))
            0: b = {b[31], 8'hFF, 23'h0};
            1: b = {b[31], 8'hFF, b[22:0] | 23'h1};
            2: b = {b[31], 31'h0};
            3: b = {b[31], 8'h00, b[22:0]};
            4: b = {b[31], 8'h7F, 20'h0, b[2:0]};
            default: ;
        endcase
        return b;
    endfunction

    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
            send_logit(pick_logit(), i == len - 1);
    endtask

    initial
    begin
        rst_n         = 0;
        valid         = 0;
        value_bits    = 0;
        last          = 0;
        no_gaps       = 0;
        stall_request = 0;
        quiet_cycles  = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_logit(32'h3F80_0000, 1);
        send_logit(32'h0000_0000, 0);
        send_logit(32'h8000_0000, 0);
        send_logit(32'hFFFF_FFFF, 1);
        send_logit(32'h7FC0_0000, 0);
        send_logit(32'hFF80_0000, 0);
        send_logit(32'h7F80_0000, 0);
        send_logit(32'hFFC0_0001, 0);
        send_logit(32'h7F7F_FFFF, 0);
        send_logit(32'hFF7F_FFFF, 0);
        send_logit(32'h0000_0001, 0);
        send_logit(32'h8000_0001, 0);
        send_logit(32'h4000_0000, 0);
        send_logit(32'h4000_0000, 0);
        send_logit(32'hC000_0000, 0);
        send_logit(32'h8000_0000, 0);
        send_logit(32'h0000_0000, 1);

        for (int v = 0; v < 8; v++)
            send_vector($urandom_range(1, 20));

        no_gaps = 1;
        for (int v = 0; v < 4; v++)
            send_vector($urandom_range(1, 8));
        no_gaps = 0;

        stall_request = 1;
        for (int v = 0; v < 6; v++)
            send_vector($urandom_range(1, 4));

        @(negedge clk);
        valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        for (int v = 0; v < 3; v++)
            send_vector($urandom_range(1, 25));

        @(negedge clk);
        valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("top_k_logit_selector regression: pass");
        else
            $display("top_k_logit_selector regression: fail");
        $finish;
    end
endmodule
